FILE: src/period_meter_band_classifier_top_defines.svh
// Assertion macros shared by the period meter RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef PERIOD_METER_BAND_CLASSIFIER_TOP_DEFINES_SVH
`define PERIOD_METER_BAND_CLASSIFIER_TOP_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define PMBC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define PMBC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define PMBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/pmbc_pkg.sv
// Shared types, widths and codes of the period meter with band classifier.
// No dependencies; every other RTL file imports this package.
package pmbc_pkg;

  // Width of the internal tick counter.
  localparam int COUNT_WIDTH = 24;

  // Fixed field widths.
  localparam int OUT_W       = 24;
  localparam int PER_W       = 10;
  localparam int CFG_W       = 24;
  localparam int CLASS_W     = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;

  // Compare width that holds both the counter and a 24-bit register.
  localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [CMP_W-1:0]       cmp_t;

  // Band classes reported with each result.
  typedef enum logic [CLASS_W-1:0] {
    CLS_NONE             = 3'd0,
    CLS_SMALL_FERROUS    = 3'd1,
    CLS_SMALL_NONFERROUS = 3'd2,
    CLS_LARGE_FERROUS    = 3'd3,
    CLS_LARGE_NONFERROUS = 3'd4,
    CLS_NO_SIGNAL        = 3'd5
  } band_class_t;

  typedef enum logic {
    ST_DONE      = 1'b0,
    ST_NO_SIGNAL = 1'b1
  } status_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIODS          = 3'd0,
    REG_TIMEOUT          = 3'd1,
    REG_LARGE_FERROUS    = 3'd2,
    REG_SMALL_FERROUS    = 3'd3,
    REG_NEUTRAL          = 3'd4,
    REG_SMALL_NONFERROUS = 3'd5
  } cfg_reg_t;

  // Reset values of the configuration registers.
  localparam logic [PER_W-1:0] RST_PERIODS          = 10'd100;
  localparam logic [CFG_W-1:0] RST_TIMEOUT          = 24'd10000000;
  localparam logic [CFG_W-1:0] RST_LARGE_FERROUS    = 24'd64102;
  localparam logic [CFG_W-1:0] RST_SMALL_FERROUS    = 24'd63938;
  localparam logic [CFG_W-1:0] RST_NEUTRAL          = 24'd63857;
  localparam logic [CFG_W-1:0] RST_SMALL_NONFERROUS = 24'd63695;

  // Current configuration as seen by the measurement core.
  typedef struct packed {
    logic [PER_W-1:0] periods;
    logic [CFG_W-1:0] timeout;
    logic [CFG_W-1:0] large_ferrous_above;
    logic [CFG_W-1:0] small_ferrous_above;
    logic [CFG_W-1:0] neutral_from;
    logic [CFG_W-1:0] small_nonferrous_from;
  } cfg_t;

  // One result item.
  typedef struct packed {
    status_t          status;
    logic [OUT_W-1:0] tick_count;
    band_class_t      band_class;
  } result_t;

endpackage

FILE: src/pmbc_cfg_regs.sv
// Configuration register file of the period meter.
// Depends on pmbc_pkg for the register indexes and the cfg_t bundle.
module pmbc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pmbc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pmbc_pkg::CFG_W-1:0]     cfg_data_i,
  output pmbc_pkg::cfg_t                 cfg_o
);
  import pmbc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Register decode; indexes beyond the list are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid_i) begin
      unique case (cfg_reg_t'(cfg_index_i))
        REG_PERIODS:          cfg_nxt.periods               = cfg_data_i[PER_W-1:0];
        REG_TIMEOUT:          cfg_nxt.timeout               = cfg_data_i;
        REG_LARGE_FERROUS:    cfg_nxt.large_ferrous_above   = cfg_data_i;
        REG_SMALL_FERROUS:    cfg_nxt.small_ferrous_above   = cfg_data_i;
        REG_NEUTRAL:          cfg_nxt.neutral_from          = cfg_data_i;
        REG_SMALL_NONFERROUS: cfg_nxt.small_nonferrous_from = cfg_data_i;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.periods               <= RST_PERIODS;
      cfg_r.timeout               <= RST_TIMEOUT;
      cfg_r.large_ferrous_above   <= RST_LARGE_FERROUS;
      cfg_r.small_ferrous_above   <= RST_SMALL_FERROUS;
      cfg_r.neutral_from          <= RST_NEUTRAL;
      cfg_r.small_nonferrous_from <= RST_SMALL_NONFERROUS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

FILE: src/pmbc_core.sv
// Measurement sequencer: edge waits, tick and period counting, classification.
// Depends on pmbc_pkg and on the assertion macros of the defines header.
`include "period_meter_band_classifier_top_defines.svh"

module pmbc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire_i,
  input  logic              start_i,
  input  logic              level_i,
  input  pmbc_pkg::cfg_t    cfg_i,
  output logic              res_emit_o,
  output pmbc_pkg::result_t res_o
);
  import pmbc_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_FIRST_LOW  = 3'd1,
    PH_FIRST_HIGH = 3'd2,
    PH_MEAS_LOW   = 3'd3,
    PH_MEAS_HIGH  = 3'd4
  } phase_t;

  phase_t           phase_r, phase_nxt;
  count_t           tick_r, tick_nxt;
  logic [PER_W-1:0] per_r, per_nxt;

  count_t           tick_inc;
  logic             wrapped;
  logic             late;
  logic             edge_seen;
  logic [PER_W-1:0] target;
  logic [PER_W-1:0] per_inc;
  cmp_t             cnt_ext;
  band_class_t      cls;

  // Saturating tick increment and timeout check.
  assign wrapped  = (tick_r == '1);
  assign tick_inc = wrapped ? tick_r : tick_r + 1'b1;
  assign cnt_ext  = CMP_W'(tick_inc);
  assign late     = wrapped || (cnt_ext > CMP_W'(cfg_i.timeout));

  // Awaited level: low in the low phases, high otherwise.
  assign edge_seen = (phase_r == PH_FIRST_LOW || phase_r == PH_MEAS_LOW) ? !level_i
                                                                        : level_i;

  // Period target, zero taken as one.
  assign target  = (cfg_i.periods == '0) ? PER_W'(1) : cfg_i.periods;
  assign per_inc = per_r + 1'b1;

  // Band classification of the finished count.
  always_comb begin
    if (cnt_ext > CMP_W'(cfg_i.large_ferrous_above)) begin
      cls = CLS_LARGE_FERROUS;
    end else if (cnt_ext > CMP_W'(cfg_i.small_ferrous_above)) begin
      cls = CLS_SMALL_FERROUS;
    end else if (cnt_ext >= CMP_W'(cfg_i.neutral_from)) begin
      cls = CLS_NONE;
    end else if (cnt_ext >= CMP_W'(cfg_i.small_nonferrous_from)) begin
      cls = CLS_SMALL_NONFERROUS;
    end else begin
      cls = CLS_LARGE_NONFERROUS;
    end
  end

  // One step of the sequencer per accepted tick.
  always_comb begin
    phase_nxt  = phase_r;
    tick_nxt   = tick_r;
    per_nxt    = per_r;
    res_emit_o = 1'b0;
    res_o.status     = ST_DONE;
    res_o.tick_count = (cnt_ext > CMP_W'(OUT_MAX)) ? OUT_MAX : cnt_ext[OUT_W-1:0];
    res_o.band_class = cls;
    if (in_fire_i) begin
      unique case (phase_r)
        PH_FIRST_LOW, PH_FIRST_HIGH, PH_MEAS_LOW, PH_MEAS_HIGH: begin
          tick_nxt = tick_inc;
          if (!edge_seen) begin
            if (late) begin
              phase_nxt        = PH_IDLE;
              tick_nxt         = '0;
              per_nxt          = '0;
              res_emit_o       = 1'b1;
              res_o.status     = ST_NO_SIGNAL;
              res_o.tick_count = '0;
              res_o.band_class = CLS_NO_SIGNAL;
            end
          end else if (phase_r == PH_FIRST_LOW) begin
            phase_nxt = PH_FIRST_HIGH;
            tick_nxt  = '0;
          end else if (phase_r == PH_FIRST_HIGH) begin
            phase_nxt = PH_MEAS_LOW;
            tick_nxt  = '0;
            per_nxt   = '0;
          end else if (phase_r == PH_MEAS_LOW) begin
            phase_nxt = PH_MEAS_HIGH;
          end else if (per_inc >= target) begin
            // Last rising edge of the counted periods.
            phase_nxt  = PH_IDLE;
            tick_nxt   = '0;
            per_nxt    = '0;
            res_emit_o = 1'b1;
          end else begin
            phase_nxt = PH_MEAS_LOW;
            per_nxt   = per_inc;
          end
        end
        default: begin
          // Idle, and unused codes behave as idle.
          phase_nxt = PH_IDLE;
          if (start_i) begin
            phase_nxt = PH_FIRST_LOW;
            tick_nxt  = '0;
            per_nxt   = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      per_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      per_r   <= per_nxt;
    end
  end

  `PMBC_ASSERT_NEXT(a_emit_rearms, res_emit_o, phase_r == PH_IDLE && tick_r == '0 && per_r == '0, "core not cleared after a result")
  `PMBC_ASSERT_IMPL(a_idle_silent, phase_r == PH_IDLE, !res_emit_o, "result emitted from idle")
  `PMBC_ASSERT_IMPL(a_status_class, res_emit_o, (res_o.status == ST_NO_SIGNAL) == (res_o.band_class == CLS_NO_SIGNAL), "status and class disagree")

endmodule

FILE: src/pmbc_out_queue.sv
// Two-entry result queue in front of the output channel.
// Depends on pmbc_pkg for result_t and on the assertion macros header.
`include "period_meter_band_classifier_top_defines.svh"

module pmbc_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  pmbc_pkg::result_t push_data_i,
  output logic              not_full_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pmbc_pkg::result_t out_data_o
);
  import pmbc_pkg::*;

  result_t    slot_r [2];
  result_t    slot_nxt [2];
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_r != 2'd0);
  assign out_data_o  = slot_r[0];
  assign not_full_o  = (count_r != 2'd2);

  // Head shifts out on a transfer; a push lands behind the remaining entries.
  always_comb begin
    slot_nxt[0] = slot_r[0];
    slot_nxt[1] = slot_r[1];
    count_nxt   = count_r;
    if (pop) begin
      slot_nxt[0] = slot_r[1];
      count_nxt   = count_nxt - 2'd1;
    end
    if (push_i) begin
      if (count_nxt == 2'd0) begin
        slot_nxt[0] = push_data_i;
      end else begin
        slot_nxt[1] = push_data_i;
      end
      count_nxt = count_nxt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r[0] <= slot_nxt[0];
    slot_r[1] <= slot_nxt[1];
  end

  `PMBC_ASSERT_ALWAYS(a_count_range, count_r != 2'd3, "queue count out of range")
  `PMBC_ASSERT_IMPL(a_no_overflow, push_i, count_r != 2'd2, "push into a full queue")
  `PMBC_ASSERT_NEXT(a_drain_step, pop && !push_i, count_r == $past(count_r) - 2'd1, "count did not drop on a transfer")

endmodule

FILE: src/period_meter_band_classifier_top.sv
// Top level of the period meter with band classifier.
// Depends on pmbc_pkg, pmbc_cfg_regs, pmbc_core and pmbc_out_queue.
//
//   channel | direction | transfer when          | payload
//   in_     | slave     | in_tvalid & in_tready  | start_request, signal_level
//   out_    | master    | out_tvalid & out_tready| status, tick_count, band_class
//   cfg_    | slave     | cfg_valid & cfg_ready  | register index, write data
//
// One input item is taken every cycle; its result, if any, is registered and
// offered on the next cycle if no older result waits. A two-entry result queue
// stalls input: in_tready drops only when both entries wait on out_tready.
// rst_n is synchronous and active low; it restores the register reset values.
// cfg_ready is always high; writes take effect on the next cycle.
module period_meter_band_classifier_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [0] start_request, [1] signal_level, [7:2] zero
  input  logic [pmbc_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [23:0] tick_count, [26:24] band_class, [31:27] zero
  output logic [pmbc_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] measure_status
  output logic                             out_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pmbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pmbc_pkg::CFG_W-1:0]       cfg_data
);
  import pmbc_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t head;
  logic    res_emit;
  logic    not_full;
  logic    in_fire;

  assign in_tready = not_full;
  assign in_fire   = in_tvalid && in_tready;

  pmbc_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .cfg_o       (cfg)
  );

  pmbc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire_i  (in_fire),
    .start_i    (in_tdata[0]),
    .level_i    (in_tdata[1]),
    .cfg_i      (cfg),
    .res_emit_o (res_emit),
    .res_o      (res)
  );

  pmbc_out_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (res_emit),
    .push_data_i (res),
    .not_full_o  (not_full),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_data_o  (head)
  );

  // Pack the result onto the output channel.
  assign out_tdata = {(OUT_TDATA_W - OUT_W - CLASS_W)'(0), head.band_class, head.tick_count};
  assign out_tuser = head.status;

endmodule
